FILE: src/kss_pkg.sv
// shared types and constants for the keyframe sprite frame selector
// no dependencies

package kss_pkg;

    localparam int FRAME_W = 16;
    localparam int DUR_W   = 24;
    localparam int TIME_W  = 32;
    localparam int SIZE_W  = 13;
    localparam int CELL_W  = 12;
    localparam int COORD_W = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KF_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRM_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRM_HEIGHT = 3'd5;

endpackage

FILE: src/keyframe_sprite_frame_select.sv
// keyframe sprite frame selector: keyframe memory, duration scans and sheet geometry
// depends on kss_pkg
//
// operation: a write does not occupy the sequencer; a query with a zero count goes straight to
//   the done state; any other query's duration is set by two scans of the keyframe memory
//   and up to eight passes of the shared restoring divider (one quotient bit per cycle)
//   for modulo, grid and coordinates
// throughput: one item at a time, busy stays high until the result strobe
// reset: asynchronous for configuration and control; result fields, data and memory undefined

module keyframe_sprite_frame_select #(
    parameter int KEYFRAMES    = 64,
    parameter int TEXTURE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [5:0]                        slot,
    input  logic [kss_pkg::FRAME_W-1:0]       frame_number,
    input  logic [kss_pkg::DUR_W-1:0]         duration,
    input  logic [kss_pkg::TIME_W-1:0]        query_time,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kss_pkg::SIZE_W-1:0]        cfg_data,
    output logic                              result_strobe,
    output logic                              frame_valid,
    output logic [kss_pkg::FRAME_W-1:0]       frame_index,
    output logic [kss_pkg::CELL_W-1:0]        cell_column,
    output logic [kss_pkg::CELL_W-1:0]        cell_row,
    output logic [kss_pkg::COORD_W-1:0]       u_left,
    output logic [kss_pkg::COORD_W-1:0]       v_top,
    output logic [kss_pkg::COORD_W-1:0]       u_right,
    output logic [kss_pkg::COORD_W-1:0]       v_bottom
);

    localparam int AW    = (KEYFRAMES > 1) ? $clog2(KEYFRAMES) : 1;
    localparam int CW    = $clog2(KEYFRAMES + 1);
    localparam int SUM_W = kss_pkg::DUR_W + CW;
    localparam int DIV_W = 34;
    localparam logic [kss_pkg::SIZE_W-1:0] SIZE_LIM = kss_pkg::SIZE_W'(1 << TEXTURE_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_TOT_RD, S_TOT_ACC, S_TIME, S_MOD_WAIT, S_SCAN_RD, S_SCAN_CHK,
        S_FRM_RD, S_FRM_GOT, S_COLS_WAIT, S_ROWS_WAIT, S_GRID, S_IX_WAIT,
        S_UL, S_UL_WAIT, S_UR, S_UR_WAIT, S_VT, S_VT_WAIT, S_VB, S_VB_WAIT, S_DONE
    } state_t;

    // keyframe memory
    logic [kss_pkg::FRAME_W-1:0] mem_frame [KEYFRAMES];
    logic [kss_pkg::DUR_W-1:0]   mem_dur   [KEYFRAMES];
    logic [kss_pkg::FRAME_W-1:0] rd_frame_reg;
    logic [kss_pkg::DUR_W-1:0]   rd_dur_reg;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;

    assign wr_en = start && !busy && (operation == kss_pkg::OP_WRITE)
                   && ({26'd0, slot} < 32'(KEYFRAMES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_frame[slot[AW-1:0]] <= frame_number;
            mem_dur[slot[AW-1:0]]   <= duration;
        end
        rd_frame_reg <= mem_frame[rd_addr];
        rd_dur_reg   <= mem_dur[rd_addr];
    end

    // configuration
    logic                         loop_reg;
    logic [6:0]                   count_cfg_reg;
    logic [kss_pkg::SIZE_W-1:0]   tw_cfg_reg, th_cfg_reg, fw_cfg_reg, fh_cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg      <= 1'b1;
            count_cfg_reg <= 7'd0;
            tw_cfg_reg    <= 13'd256;
            th_cfg_reg    <= 13'd256;
            fw_cfg_reg    <= 13'd16;
            fh_cfg_reg    <= 13'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                kss_pkg::REG_LOOP_MODE:  loop_reg      <= cfg_data[0];
                kss_pkg::REG_KF_COUNT:   count_cfg_reg <= cfg_data[6:0];
                kss_pkg::REG_TEX_WIDTH:  tw_cfg_reg    <= cfg_data;
                kss_pkg::REG_TEX_HEIGHT: th_cfg_reg    <= cfg_data;
                kss_pkg::REG_FRM_WIDTH:  fw_cfg_reg    <= cfg_data;
                kss_pkg::REG_FRM_HEIGHT: fh_cfg_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW-1:0] count;
    logic [kss_pkg::SIZE_W-1:0] tw, th, fw, fh;
    assign count = (32'(count_cfg_reg) > 32'(KEYFRAMES)) ? CW'(KEYFRAMES) : CW'(count_cfg_reg);
    assign tw = (tw_cfg_reg > SIZE_LIM) ? SIZE_LIM : tw_cfg_reg;
    assign th = (th_cfg_reg > SIZE_LIM) ? SIZE_LIM : th_cfg_reg;
    assign fw = (fw_cfg_reg > SIZE_LIM) ? SIZE_LIM : fw_cfg_reg;
    assign fh = (fh_cfg_reg > SIZE_LIM) ? SIZE_LIM : fh_cfg_reg;

    // shared restoring divider, one quotient bit per cycle
    logic             div_go;
    logic [DIV_W-1:0] div_num, div_den;
    logic [DIV_W-1:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]       dcnt_reg;
    logic             dbusy_reg;
    logic [DIV_W:0]   dtrial;

    assign dtrial = {dr_reg, dq_reg[DIV_W-1]} - {1'b0, dd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= 6'd0;
        end
        else if (div_go)
        begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= 6'(DIV_W);
            dq_reg    <= div_num;
            dr_reg    <= '0;
            dd_reg    <= div_den;
        end
        else if (dbusy_reg)
        begin
            if (dtrial[DIV_W])
            begin
                dr_reg <= {dr_reg[DIV_W-2:0], dq_reg[DIV_W-1]};
                dq_reg <= {dq_reg[DIV_W-2:0], 1'b0};
            end
            else
            begin
                dr_reg <= dtrial[DIV_W-1:0];
                dq_reg <= {dq_reg[DIV_W-2:0], 1'b1};
            end
            dcnt_reg <= dcnt_reg - 6'd1;
            if (dcnt_reg == 6'd1)
                dbusy_reg <= 1'b0;
        end
    end

    // sequencer
    state_t                     state_reg;
    logic [CW-1:0]              idx_reg;
    logic [SUM_W-1:0]           total_reg, sum_reg;
    logic [kss_pkg::TIME_W-1:0] qtime_reg;
    logic [SUM_W-1:0]           t_reg;
    logic [kss_pkg::FRAME_W-1:0] frame_reg;
    logic [12:0]                cols_reg, rows_reg;
    logic [kss_pkg::CELL_W-1:0] ix_reg, iy_reg;
    logic [SUM_W-1:0]           next_sum;
    logic [25:0]                grid;
    logic [25:0]                px;

    assign next_sum = sum_reg + SUM_W'(rd_dur_reg);
    assign grid     = 26'(cols_reg) * 26'(rows_reg);
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        div_go  = 1'b0;
        div_num = '0;
        div_den = '1;
        px      = '0;
        unique case (state_reg)
            S_TIME:
            begin
                div_go  = (total_reg != '0) && loop_reg;
                div_num = DIV_W'(qtime_reg);
                div_den = DIV_W'(total_reg);
            end
            S_FRM_RD: rd_addr = '0;
            S_FRM_GOT:
            begin
                div_go  = 1'b1;
                div_num = DIV_W'(tw);
                div_den = (fw == '0) ? '1 : DIV_W'(fw);
            end
            S_COLS_WAIT:
            begin
                div_go  = !dbusy_reg;
                div_num = DIV_W'(th);
                div_den = (fh == '0) ? '1 : DIV_W'(fh);
            end
            S_GRID:
            begin
                div_go  = 1'b1;
                div_num = DIV_W'(frame_reg);
                div_den = DIV_W'(cols_reg);
            end
            S_UL, S_UR, S_VT, S_VB:
            begin
                unique case (state_reg)
                    S_UL: px = 26'(ix_reg) * 26'(fw);
                    S_UR: px = (26'(ix_reg) + 26'd1) * 26'(fw);
                    S_VT: px = 26'(iy_reg) * 26'(fh);
                    default: px = (26'(iy_reg) + 26'd1) * 26'(fh);
                endcase
                div_go  = 1'b1;
                div_num = {px[17:0], 16'd0};
                div_den = (state_reg == S_UL || state_reg == S_UR) ? DIV_W'(tw) : DIV_W'(th);
            end
            default: ;
        endcase
    end

    function automatic logic [16:0] clip_coord(input logic [DIV_W-1:0] q);
        clip_coord = (q > 34'd65536) ? 17'd65536 : q[16:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            result_strobe <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            result_strobe <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (start && operation == kss_pkg::OP_QUERY)
                    begin
                        qtime_reg   <= query_time;
                        idx_reg     <= '0;
                        total_reg   <= '0;
                        frame_valid <= 1'b0;
                        frame_index <= '0;
                        cell_column <= '0;
                        cell_row    <= '0;
                        u_left      <= '0;
                        v_top       <= '0;
                        u_right     <= '0;
                        v_bottom    <= '0;
                        state_reg   <= (count_cfg_reg == 7'd0) ? S_DONE : S_TOT_RD;
                    end
                S_TOT_RD:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_TOT_ACC;
                end
                S_TOT_ACC:
                begin
                    total_reg <= total_reg + SUM_W'(rd_dur_reg);
                    state_reg <= (idx_reg == count) ? S_TIME : S_TOT_RD;
                end
                S_TIME:
                begin
                    idx_reg   <= '0;
                    sum_reg   <= '0;
                    if (total_reg == '0)
                    begin
                        t_reg     <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                    else if (loop_reg)
                        state_reg <= S_MOD_WAIT;
                    else
                    begin
                        t_reg <= ((kss_pkg::TIME_W+1)'(qtime_reg)
                                  >= (kss_pkg::TIME_W+1)'(total_reg)) ? total_reg - 1'b1
                                                                      : SUM_W'(qtime_reg);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_MOD_WAIT:
                    if (!dbusy_reg)
                    begin
                        t_reg     <= dr_reg[SUM_W-1:0];
                        state_reg <= S_SCAN_RD;
                    end
                S_SCAN_RD:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                    if (t_reg < next_sum)
                    begin
                        frame_reg <= rd_frame_reg;
                        state_reg <= S_FRM_GOT;
                    end
                    else
                    begin
                        sum_reg   <= next_sum;
                        state_reg <= (idx_reg == count) ? S_FRM_RD : S_SCAN_RD;
                    end
                S_FRM_RD:
                    state_reg <= S_IX_WAIT;
                S_FRM_GOT:
                begin
                    frame_index <= frame_reg;
                    state_reg   <= S_COLS_WAIT;
                end
                S_COLS_WAIT:
                    if (!dbusy_reg)
                    begin
                        cols_reg  <= (fw == '0) ? 13'd0 : dq_reg[12:0];
                        state_reg <= S_ROWS_WAIT;
                    end
                S_ROWS_WAIT:
                    if (!dbusy_reg && !div_go)
                    begin
                        rows_reg  <= (fh == '0) ? 13'd0 : dq_reg[12:0];
                        state_reg <= S_GRID;
                    end
                S_GRID:
                    // frame outside the grid ends with the cleared fields
                    if (cols_reg == '0 || rows_reg == '0 || 26'(frame_reg) >= grid)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_UL_WAIT;
                S_IX_WAIT:
                begin
                    // fallback path: keyframe 0 read lands here
                    frame_reg   <= rd_frame_reg;
                    frame_index <= rd_frame_reg;
                    state_reg   <= S_FRM_GOT;
                end
                S_UL_WAIT:
                    if (!dbusy_reg)
                    begin
                        ix_reg    <= dr_reg[11:0];
                        iy_reg    <= dq_reg[11:0];
                        state_reg <= S_UL;
                    end
                S_UL: state_reg <= S_UR_WAIT;
                S_UR_WAIT:
                    if (!dbusy_reg)
                    begin
                        u_left    <= clip_coord(dq_reg);
                        state_reg <= S_UR;
                    end
                S_UR: state_reg <= S_VT_WAIT;
                S_VT_WAIT:
                    if (!dbusy_reg)
                    begin
                        u_right   <= clip_coord(dq_reg);
                        state_reg <= S_VT;
                    end
                S_VT: state_reg <= S_VB_WAIT;
                S_VB_WAIT:
                    if (!dbusy_reg)
                    begin
                        v_top     <= clip_coord(dq_reg);
                        state_reg <= S_VB;
                    end
                S_VB: state_reg <= S_DONE;
                S_DONE:
                    if (!dbusy_reg)
                    begin
                        if (cols_reg != '0 && rows_reg != '0 && 26'(frame_reg) < grid
                            && count_cfg_reg != 7'd0)
                        begin
                            frame_valid <= 1'b1;
                            cell_column <= ix_reg;
                            cell_row    <= iy_reg;
                            v_bottom    <= clip_coord(dq_reg);
                        end
                        result_strobe <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
            // zero count or outside grid must not pick up stale geometry
            if (state_reg == S_IDLE && start)
            begin
                cols_reg <= '0;
                rows_reg <= '0;
            end
        end
    end

    // divider never started while still running
    assert property (@(posedge clk) disable iff (!rst_n) div_go |-> !dbusy_reg)
        else $error("divider restarted while busy");
    // result only leaves from the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg) == S_DONE)
        else $error("result strobe outside done state");
    // a write never occupies the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == kss_pkg::OP_WRITE) |=> !busy)
        else $error("write left block busy");

endmodule
